@@ rtl/core/matrix3_inverse_unit_macros.svh @@
`ifndef MATRIX3_INVERSE_UNIT_MACROS_SVH
`define MATRIX3_INVERSE_UNIT_MACROS_SVH

// same-cycle implication, ignored while in reset
`define M3I_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, ignored while in reset
`define M3I_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define M3I_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/m3i_pkg.sv @@
`default_nettype none
package m3i_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  localparam int N_ELEM    = 9;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int ADJ_W     = PROD_W + 1;
  localparam int ADJ_MAG_W = PROD_W;
  localparam int PP_W      = ADJ_MAG_W + ELEM_W;
  localparam int DET_W     = PP_W + 2;
  localparam int Q_BITS    = ELEM_W;
  localparam int WIDE_W    = DET_W + Q_BITS;
  localparam int ADJ_LAT   = 4;
  localparam int DIV_LAT   = Q_BITS + 2;
  localparam int PIPE_LAT  = ADJ_LAT + DIV_LAT;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [ADJ_W-1:0]  adj_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic [N_ELEM-1:0][ELEM_W-1:0] mat_t;
  typedef logic [N_ELEM-1:0][ADJ_W-1:0]  adj_vec_t;

  typedef struct packed {
    logic  invertible;
    elem_t value;
  } lane_res_t;

endpackage
`default_nettype wire

@@ rtl/core/m3i_in_if.sv @@
`default_nettype none
interface m3i_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  input ready);
  modport sink (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                output ready);
  modport mon (input valid, ready, a00, a01, a02, a10, a11, a12, a20, a21, a22);
endinterface
`default_nettype wire

@@ rtl/core/m3i_out_if.sv @@
`default_nettype none
interface m3i_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic invertible;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  invertible, input ready);
  modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                invertible, output ready);
  modport mon (input valid, ready, r00, r01, r02, r10, r11, r12, r20, r21, r22,
               invertible);
endinterface
`default_nettype wire

@@ rtl/core/m3i_adjugate.sv @@
`default_nettype none
module m3i_adjugate (
  input  logic               clk,
  input  logic               en,
  input  m3i_pkg::mat_t      mat,
  output m3i_pkg::mat_t      mat_dly,
  output m3i_pkg::adj_vec_t  adj,
  output m3i_pkg::det_t      det
);

  // cofactor operands: adj[i] = m[p]*m[q] - m[r]*m[s]
  localparam int COF_P [9] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
  localparam int COF_Q [9] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
  localparam int COF_R [9] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
  localparam int COF_S [9] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

  logic signed [m3i_pkg::PROD_W-1:0] s1_prod [2*m3i_pkg::N_ELEM];
  m3i_pkg::mat_t     s1_mat, s2_mat, s3_mat;
  m3i_pkg::adj_vec_t s2_adj, s3_adj;
  logic [m3i_pkg::PROD_W-1:0] s3_pl [3];
  logic [m3i_pkg::PROD_W-1:0] s3_ph [3];
  logic [2:0] s3_neg;

  logic [m3i_pkg::ADJ_W-1:0]     s2_abs [3];
  logic [m3i_pkg::ADJ_MAG_W-1:0] s2_mag [3];
  logic [m3i_pkg::ELEM_W-1:0]    s2_amag [3];
  logic [2:0]                    s2_neg;
  logic [m3i_pkg::PP_W-1:0]      s3_m [3];
  logic [m3i_pkg::DET_W-1:0]     s3_term [3];

  // sign and magnitude of the first-row cofactors and first-row elements
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s2_abs[j]  = s2_adj[3*j][m3i_pkg::ADJ_W-1] ? -s2_adj[3*j] : s2_adj[3*j];
      s2_mag[j]  = s2_abs[j][m3i_pkg::ADJ_MAG_W-1:0];
      s2_amag[j] = s2_mat[j][m3i_pkg::ELEM_W-1] ? -s2_mat[j] : s2_mat[j];
      s2_neg[j]  = s2_adj[3*j][m3i_pkg::ADJ_W-1] ^ s2_mat[j][m3i_pkg::ELEM_W-1];
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s3_m[j] = {s3_ph[j], {m3i_pkg::ELEM_W{1'b0}}}
              + {{m3i_pkg::ELEM_W{1'b0}}, s3_pl[j]};
      s3_term[j] = s3_neg[j] ? -{2'b00, s3_m[j]} : {2'b00, s3_m[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < m3i_pkg::N_ELEM; i++) begin
        s1_prod[2*i]   <= $signed(mat[COF_P[i]]) * $signed(mat[COF_Q[i]]);
        s1_prod[2*i+1] <= $signed(mat[COF_R[i]]) * $signed(mat[COF_S[i]]);
        s2_adj[i] <= m3i_pkg::ADJ_W'(s1_prod[2*i]) - m3i_pkg::ADJ_W'(s1_prod[2*i+1]);
      end
      s1_mat <= mat;
      s2_mat <= s1_mat;
      // wide product split into two 32x32 halves
      for (int j = 0; j < 3; j++) begin
        s3_pl[j] <= s2_mag[j][m3i_pkg::ELEM_W-1:0] * s2_amag[j];
        s3_ph[j] <= s2_mag[j][m3i_pkg::ADJ_MAG_W-1:m3i_pkg::ELEM_W] * s2_amag[j];
      end
      s3_neg  <= s2_neg;
      s3_adj  <= s2_adj;
      s3_mat  <= s2_mat;
      det     <= s3_term[0] + s3_term[1] + s3_term[2];
      adj     <= s3_adj;
      mat_dly <= s3_mat;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/m3i_div_lane.sv @@
`default_nettype none
module m3i_div_lane (
  input  logic               clk,
  input  logic               en,
  input  m3i_pkg::adj_t      adj,
  input  m3i_pkg::det_t      det,
  input  m3i_pkg::elem_t     elem,
  output m3i_pkg::lane_res_t res
);

  localparam int QB = m3i_pkg::Q_BITS;
  localparam int WW = m3i_pkg::WIDE_W;
  localparam int DW = m3i_pkg::DET_W;
  localparam logic [QB-1:0] SAT_POS = {1'b0, {(QB-1){1'b1}}};
  localparam logic [QB-1:0] SAT_NEG = {1'b1, {(QB-1){1'b0}}};

  logic [WW-1:0]  st_rem  [QB+1];
  logic [DW-1:0]  st_div  [QB+1];
  logic [QB-1:0]  st_q    [QB+1];
  logic           st_neg  [QB+1];
  logic           st_zero [QB+1];
  logic           st_over [QB+1];
  m3i_pkg::elem_t st_elem [QB+1];

  logic [m3i_pkg::ADJ_W-1:0] adj_abs;
  logic [DW-1:0]             det_mag;
  logic [WW-1:0]             num;
  logic                      over;

  always_comb begin
    adj_abs = adj[m3i_pkg::ADJ_W-1] ? -adj : adj;
    det_mag = det[DW-1] ? -det : det;
    num     = WW'(adj_abs[m3i_pkg::ADJ_MAG_W-1:0]) << (2 * m3i_pkg::FRAC_BITS);
    // quotient of 2^32 or more saturates whatever the sign
    over    = num >= {det_mag, {QB{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_rem[0]  <= num;
      st_div[0]  <= det_mag;
      st_q[0]    <= '0;
      st_neg[0]  <= adj[m3i_pkg::ADJ_W-1] ^ det[DW-1];
      st_zero[0] <= (det == '0);
      st_over[0] <= over;
      st_elem[0] <= elem;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int B = QB - 1 - k;
    logic [WW-1:0] trial;
    logic          ge;
    logic [QB-1:0] qn;

    always_comb begin
      trial = WW'(st_div[k]) << B;
      ge    = st_rem[k] >= trial;
      qn    = st_q[k];
      qn[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_rem[k+1]  <= ge ? st_rem[k] - trial : st_rem[k];
        st_div[k+1]  <= st_div[k];
        st_q[k+1]    <= qn;
        st_neg[k+1]  <= st_neg[k];
        st_zero[k+1] <= st_zero[k];
        st_over[k+1] <= st_over[k];
        st_elem[k+1] <= st_elem[k];
      end
    end
  end

  logic [QB-1:0] q;
  assign q = st_q[QB];

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (st_zero[QB]) begin
        res.invertible <= 1'b0;
        res.value      <= st_elem[QB];
      end else if (!st_neg[QB]) begin
        res.invertible <= 1'b1;
        res.value      <= (st_over[QB] || q > SAT_POS) ? SAT_POS : q;
      end else begin
        res.invertible <= 1'b1;
        res.value      <= (st_over[QB] || q > SAT_NEG) ? SAT_NEG : -q;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/matrix3_inverse_unit.sv @@
// 3x3 inverse of signed Q16.16 matrices by adjugate and determinant. A new matrix
// is taken in every cycle and each result passes through the cofactor and
// determinant arithmetic, nine divider lanes that yield one quotient bit per stage,
// and the output register; the whole pipe only holds while a finished result is
// not taken. A zero determinant gives back the input matrix with invertible low;
// otherwise each element is truncated toward zero and saturated to the Q16.16
// range.
`default_nettype none
module matrix3_inverse_unit (
  input  logic             clk,
  input  logic             rst,
  m3i_in_if.sink           item,
  m3i_out_if.source        result
);

  logic                       en;
  logic [m3i_pkg::PIPE_LAT-1:0] vld;
  m3i_pkg::mat_t              mat, mat_dly;
  m3i_pkg::adj_vec_t          adj;
  m3i_pkg::det_t              det;
  m3i_pkg::lane_res_t         lane_res [m3i_pkg::N_ELEM];

  assign en         = !result.valid || result.ready;
  assign item.ready = en;

  assign mat = {item.a22, item.a21, item.a20, item.a12, item.a11, item.a10,
                item.a02, item.a01, item.a00};

  m3i_adjugate u_adj (
    .clk     (clk),
    .en      (en),
    .mat     (mat),
    .mat_dly (mat_dly),
    .adj     (adj),
    .det     (det)
  );

  for (genvar i = 0; i < m3i_pkg::N_ELEM; i++) begin : g_lane
    m3i_div_lane u_lane (
      .clk  (clk),
      .en   (en),
      .adj  (adj[i]),
      .det  (det),
      .elem (mat_dly[i]),
      .res  (lane_res[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      result.valid <= 1'b0;
    end else if (en) begin
      vld          <= {vld[m3i_pkg::PIPE_LAT-2:0], item.valid};
      result.valid <= vld[m3i_pkg::PIPE_LAT-1];
    end
  end

  // merge the lanes into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      result.r00        <= lane_res[0].value;
      result.r01        <= lane_res[1].value;
      result.r02        <= lane_res[2].value;
      result.r10        <= lane_res[3].value;
      result.r11        <= lane_res[4].value;
      result.r12        <= lane_res[5].value;
      result.r20        <= lane_res[6].value;
      result.r21        <= lane_res[7].value;
      result.r22        <= lane_res[8].value;
      result.invertible <= lane_res[0].invertible;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/m3i_checker.sv @@
`default_nettype none
`include "matrix3_inverse_unit_macros.svh"
module m3i_checker (
  input logic       clk,
  input logic       rst,
  m3i_in_if.sink    item,
  m3i_out_if.source result
);

  // no transaction may appear straight after reset
  `M3I_ASSERT_ALWAYS(a_rst_clear, rst, !result.valid, "result valid after reset")

  // an empty output register never holds back the input
  `M3I_ASSERT_NOW(a_ready_free, !result.valid, item.ready, "input stalled with empty output")

  `M3I_ASSERT_NEXT(a_hold_valid, result.valid && !result.ready, result.valid, "result dropped")

  `M3I_ASSERT_NEXT(a_hold_data, result.valid && !result.ready, $stable(result.r00) && $stable(result.r11) && $stable(result.r22) && $stable(result.invertible), "stalled result changed")

endmodule

bind matrix3_inverse_unit m3i_checker u_m3i_checker (
  .clk    (clk),
  .rst    (rst),
  .item   (item),
  .result (result)
);
`default_nettype wire
